@@ hw/rtl/saturating_event_statistics_core_defines.svh @@
// Assertion macros for the saturating event statistics core.
// Taken in by the RTL files that carry concurrent checks; depends on nothing.
`ifndef SATURATING_EVENT_STATISTICS_CORE_DEFINES_SVH
`define SATURATING_EVENT_STATISTICS_CORE_DEFINES_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define SES_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ses same-cycle check failed");

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define SES_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ses next-cycle check failed");

`endif

@@ hw/rtl/ses_pkg.sv @@
// Shared types and constants for the saturating event statistics core.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package ses_pkg;

  localparam int TICK_WIDTH    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int RATIO_BITS    = 16;

  localparam int CMD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 64;
  localparam int IDX_W   = 4;
  localparam int RATIO_W = RATIO_BITS + 1;

  // Dividend of the fixed-point divider: a 64-bit value with the fraction appended.
  localparam int DIV_NUM_W = TOTAL_W + FRACTION_BITS;

  localparam logic [WORD_W-1:0] TICK_MASK = (TICK_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
      WORD_W'((64'd1 << TICK_WIDTH) - 64'd1);

  // Counter order for the read command.
  localparam logic [IDX_W-1:0] CTR_OK      = 4'd0;
  localparam logic [IDX_W-1:0] CTR_FAIL    = 4'd1;
  localparam logic [IDX_W-1:0] CTR_BYTES   = 4'd2;
  localparam logic [IDX_W-1:0] CTR_LAT_TOT = 4'd3;
  localparam logic [IDX_W-1:0] CTR_PEAK    = 4'd4;
  localparam logic [IDX_W-1:0] CTR_SAMPLES = 4'd5;
  localparam logic [IDX_W-1:0] CTR_CRC     = 4'd6;
  localparam logic [IDX_W-1:0] CTR_TIMEOUT = 4'd7;
  localparam logic [IDX_W-1:0] CTR_IRQ     = 4'd8;
  localparam logic [IDX_W-1:0] CTR_RST_EVT = 4'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRANSFER  = 3'd0,
    CMD_CRC       = 3'd1,
    CMD_TIMEOUT   = 3'd2,
    CMD_INTERRUPT = 3'd3,
    CMD_RESET_EVT = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_DERIVE    = 3'd6,
    CMD_READ      = 3'd7
  } ses_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_TPUT,
    ST_RATIO,
    ST_EMIT
  } ses_state_e;

  // Classified request as it sits in the queue.
  typedef struct packed {
    ses_cmd_e          cmd;
    logic              ok;
    logic [WORD_W-1:0] bytes;
    logic [WORD_W-1:0] lat;
    logic [WORD_W-1:0] ela;
    logic [IDX_W-1:0]  idx;
  } ses_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [WORD_W-1:0]    den;
  } ses_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [TOTAL_W-1:0] value;
  } ses_div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ses_in_if.sv @@
// Request channel of the saturating event statistics core.
// Depends on ses_pkg for field widths.
`default_nettype none

interface ses_in_if;
  logic                         valid;
  logic                         ready;
  logic [ses_pkg::CMD_W-1:0]    command;
  logic                         transfer_ok;
  logic [ses_pkg::WORD_W-1:0]   byte_count;
  logic [ses_pkg::WORD_W-1:0]   latency;
  logic [ses_pkg::WORD_W-1:0]   elapsed;
  logic [ses_pkg::IDX_W-1:0]    counter_index;

  modport source (output valid, command, transfer_ok, byte_count, latency, elapsed,
                  counter_index, input ready);
  modport sink (input valid, command, transfer_ok, byte_count, latency, elapsed,
                counter_index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ses_out_if.sv @@
// Result channel of the saturating event statistics core.
// Depends on ses_pkg for field widths.
`default_nettype none

interface ses_out_if;
  logic                         valid;
  logic                         ready;
  logic [ses_pkg::TOTAL_W-1:0]  counter_value;
  logic [ses_pkg::TOTAL_W-1:0]  mean_latency;
  logic [ses_pkg::WORD_W-1:0]   max_latency;
  logic [ses_pkg::TOTAL_W-1:0]  throughput;
  logic [ses_pkg::RATIO_W-1:0]  success_ratio;

  modport source (output valid, counter_value, mean_latency, max_latency, throughput,
                  success_ratio, input ready);
  modport sink (input valid, counter_value, mean_latency, max_latency, throughput,
                success_ratio, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/saturating_event_statistics_core.sv @@
// Saturating event statistics core. Requests enter a two-deep queue that
// takes one request per cycle while it has room. Transfer, error, interrupt,
// reset-event and clear requests each retire as soon as they reach an idle
// back end, so a stream of them runs at one per cycle while no derive holds
// it. A read retires once the result register is free. A derive runs three
// quotients (mean latency, throughput, success ratio) one after another
// through a single divider that produces one quotient bit per cycle. The
// back end starts each quotient, collects it when the divider is done, and
// after the last one loads the result register, so a derive holds the back
// end until its result is loaded, including any wait for the result
// register; requests queue behind it meanwhile. Results leave through a
// one-entry output register, so the next request other than a read is taken
// while a result waits.
`default_nettype none

module saturating_event_statistics_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ses_in_if.sink    req_i,
  ses_out_if.source rsp_o
);

  logic                  head_valid;
  ses_pkg::ses_item_t    head;
  logic                  pop;
  ses_pkg::ses_div_req_t div_req;
  ses_pkg::ses_div_rsp_t div_rsp;

  ses_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  ses_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ses_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ses_front.sv @@
// Front end: accepts requests, decodes and masks them, and queues them.
// Depends on ses_pkg and ses_in_if.
`default_nettype none

module ses_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  ses_in_if.sink                  req_i,
  output      logic               head_valid_o,
  output      ses_pkg::ses_item_t head_o,
  input  wire logic               pop_i
);

  ses_pkg::ses_item_t fifo_q [2];
  ses_pkg::ses_item_t item;
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               push;
  logic               pop;

  always_comb begin
    item.cmd   = ses_pkg::ses_cmd_e'(req_i.command);
    item.ok    = req_i.transfer_ok;
    item.bytes = req_i.byte_count;
    item.lat   = req_i.latency & ses_pkg::TICK_MASK;
    item.ela   = req_i.elapsed & ses_pkg::TICK_MASK;
    item.idx   = req_i.counter_index;
  end

  assign req_i.ready  = (count_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ses_div.sv @@
// Bit-serial fixed-point divider, one quotient bit per cycle.
// Saturates to all ones above 64 bits and returns 0 for a zero divisor.
// Depends on ses_pkg.
`default_nettype none

module ses_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ses_pkg::ses_div_req_t req_i,
  output      ses_pkg::ses_div_rsp_t rsp_o
);

  localparam int NumW = ses_pkg::DIV_NUM_W;
  localparam int DenW = ses_pkg::WORD_W;
  localparam int ValW = ses_pkg::TOTAL_W;
  localparam int CntW = $clog2(NumW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                den_zero_q;
  logic [DenW-1:0]     den_q;
  logic [DenW-1:0]     rem_q, rem_d;
  logic [NumW-1:0]     work_q, work_d;
  logic [ValW-1:0]     value_q, value_d;
  logic [DenW:0]       shifted;
  logic [DenW:0]       diff;
  logic                take;
  logic                start;

  assign start   = req_i.start && !busy_q;
  assign shifted = {rem_q, work_q[NumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    work_d  = work_q;
    value_d = value_q;
    if (start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      rem_d  = '0;
      work_d = req_i.num;
    end else if (busy_q) begin
      rem_d  = take ? diff[DenW-1:0] : shifted[DenW-1:0];
      work_d = {work_q[NumW-2:0], take};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (den_zero_q) begin
          value_d = '0;
        end else if (|work_d[NumW-1:ValW]) begin
          value_d = '1;
        end else begin
          value_d = work_d[ValW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    work_q  <= work_d;
    value_q <= value_d;
    if (start) begin
      den_q      <= req_i.den;
      den_zero_q <= (req_i.den == '0);
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

`default_nettype wire

@@ hw/rtl/ses_back.sv @@
// Back end: counter file, command sequencer and result register.
// Drives the shared divider for derive requests.
// Depends on ses_pkg, ses_out_if and the assertion macro header.
`default_nettype none
`include "saturating_event_statistics_core_defines.svh"

module ses_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_valid_i,
  input  wire ses_pkg::ses_item_t    head_i,
  output      logic                  pop_o,
  output      ses_pkg::ses_div_req_t div_req_o,
  input  wire ses_pkg::ses_div_rsp_t div_rsp_i,
  ses_out_if.source                  rsp_o
);

  localparam int WordW = ses_pkg::WORD_W;
  localparam int TotW  = ses_pkg::TOTAL_W;
  localparam int NumW  = ses_pkg::DIV_NUM_W;
  localparam int FracW = ses_pkg::FRACTION_BITS;
  localparam int RatW  = ses_pkg::RATIO_BITS;

  function automatic logic [WordW-1:0] inc32(input logic [WordW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [TotW-1:0] add64(input logic [TotW-1:0] a,
                                            input logic [WordW-1:0] b);
    logic [TotW:0] s;
    s = {1'b0, a} + {{(TotW - WordW + 1){1'b0}}, b};
    return s[TotW] ? '1 : s[TotW-1:0];
  endfunction

  ses_pkg::ses_state_e state_q, state_d;

  logic [WordW-1:0] ok_q, ok_d, fail_q, fail_d;
  logic [TotW-1:0]  bytes_q, bytes_d, lat_tot_q, lat_tot_d;
  logic [WordW-1:0] peak_q, peak_d, samples_q, samples_d;
  logic [WordW-1:0] crc_q, crc_d, tmo_q, tmo_d, irq_q, irq_d, rst_evt_q, rst_evt_d;

  logic [WordW-1:0]         ela_q, ela_d;
  logic [TotW-1:0]          mean_q, mean_d, tput_q, tput_d;
  logic [ses_pkg::RATIO_W-1:0] ratio_q, ratio_d;

  logic                     out_valid_q, out_valid_d;
  logic [TotW-1:0]          out_cv_q, out_cv_d, out_mean_q, out_mean_d;
  logic [WordW-1:0]         out_max_q, out_max_d;
  logic [TotW-1:0]          out_tput_q, out_tput_d;
  logic [ses_pkg::RATIO_W-1:0] out_ratio_q, out_ratio_d;

  logic             out_free;
  logic             out_load;
  logic [WordW:0]   total_sum;
  logic [WordW-1:0] total;
  logic [TotW-1:0]  picked;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign total_sum = {1'b0, ok_q} + {1'b0, fail_q};
  assign total     = total_sum[WordW] ? '1 : total_sum[WordW-1:0];

  always_comb begin
    case (head_i.idx)
      ses_pkg::CTR_OK:      picked = {{(TotW - WordW){1'b0}}, ok_q};
      ses_pkg::CTR_FAIL:    picked = {{(TotW - WordW){1'b0}}, fail_q};
      ses_pkg::CTR_BYTES:   picked = bytes_q;
      ses_pkg::CTR_LAT_TOT: picked = lat_tot_q;
      ses_pkg::CTR_PEAK:    picked = {{(TotW - WordW){1'b0}}, peak_q};
      ses_pkg::CTR_SAMPLES: picked = {{(TotW - WordW){1'b0}}, samples_q};
      ses_pkg::CTR_CRC:     picked = {{(TotW - WordW){1'b0}}, crc_q};
      ses_pkg::CTR_TIMEOUT: picked = {{(TotW - WordW){1'b0}}, tmo_q};
      ses_pkg::CTR_IRQ:     picked = {{(TotW - WordW){1'b0}}, irq_q};
      ses_pkg::CTR_RST_EVT: picked = {{(TotW - WordW){1'b0}}, rst_evt_q};
      default:              picked = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    div_req_o   = '0;
    ok_d        = ok_q;
    fail_d      = fail_q;
    bytes_d     = bytes_q;
    lat_tot_d   = lat_tot_q;
    peak_d      = peak_q;
    samples_d   = samples_q;
    crc_d       = crc_q;
    tmo_d       = tmo_q;
    irq_d       = irq_q;
    rst_evt_d   = rst_evt_q;
    ela_d       = ela_q;
    mean_d      = mean_q;
    tput_d      = tput_q;
    ratio_d     = ratio_q;
    out_cv_d    = out_cv_q;
    out_mean_d  = out_mean_q;
    out_max_d   = out_max_q;
    out_tput_d  = out_tput_q;
    out_ratio_d = out_ratio_q;

    case (state_q)
      ses_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.cmd)
            ses_pkg::CMD_TRANSFER: begin
              pop_o = 1'b1;
              if (head_i.ok) begin
                ok_d = inc32(ok_q);
              end else begin
                fail_d = inc32(fail_q);
              end
              bytes_d   = add64(bytes_q, head_i.bytes);
              lat_tot_d = add64(lat_tot_q, head_i.lat);
              if (head_i.lat > peak_q) begin
                peak_d = head_i.lat;
              end
              samples_d = inc32(samples_q);
            end
            ses_pkg::CMD_CRC: begin
              pop_o = 1'b1;
              crc_d = inc32(crc_q);
            end
            ses_pkg::CMD_TIMEOUT: begin
              pop_o = 1'b1;
              tmo_d = inc32(tmo_q);
            end
            ses_pkg::CMD_INTERRUPT: begin
              pop_o = 1'b1;
              irq_d = inc32(irq_q);
            end
            ses_pkg::CMD_RESET_EVT: begin
              pop_o     = 1'b1;
              rst_evt_d = inc32(rst_evt_q);
            end
            ses_pkg::CMD_CLEAR: begin
              pop_o     = 1'b1;
              ok_d      = '0;
              fail_d    = '0;
              bytes_d   = '0;
              lat_tot_d = '0;
              peak_d    = '0;
              samples_d = '0;
              crc_d     = '0;
              tmo_d     = '0;
              irq_d     = '0;
              rst_evt_d = '0;
            end
            ses_pkg::CMD_DERIVE: begin
              // Counters hold still until the result is loaded: nothing else pops meanwhile.
              pop_o           = 1'b1;
              ela_d           = head_i.ela;
              div_req_o.start = 1'b1;
              div_req_o.num   = {lat_tot_q, {FracW{1'b0}}};
              div_req_o.den   = samples_q;
              state_d         = ses_pkg::ST_MEAN;
            end
            ses_pkg::CMD_READ: begin
              if (out_free) begin
                pop_o       = 1'b1;
                out_load    = 1'b1;
                out_cv_d    = picked;
                out_mean_d  = '0;
                out_max_d   = '0;
                out_tput_d  = '0;
                out_ratio_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ses_pkg::ST_MEAN: begin
        if (div_rsp_i.done) begin
          mean_d          = div_rsp_i.value;
          div_req_o.start = 1'b1;
          div_req_o.num   = {bytes_q, {FracW{1'b0}}};
          div_req_o.den   = ela_q;
          state_d         = ses_pkg::ST_TPUT;
        end
      end
      ses_pkg::ST_TPUT: begin
        if (div_rsp_i.done) begin
          tput_d          = div_rsp_i.value;
          div_req_o.start = 1'b1;
          div_req_o.num   = {{(NumW - WordW - RatW){1'b0}}, ok_q, {RatW{1'b0}}};
          div_req_o.den   = total;
          state_d         = ses_pkg::ST_RATIO;
        end
      end
      ses_pkg::ST_RATIO: begin
        if (div_rsp_i.done) begin
          ratio_d = div_rsp_i.value[ses_pkg::RATIO_W-1:0];
          state_d = ses_pkg::ST_EMIT;
        end
      end
      ses_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_cv_d    = '0;
          out_mean_d  = mean_q;
          out_max_d   = peak_q;
          out_tput_d  = tput_q;
          out_ratio_d = ratio_q;
          state_d     = ses_pkg::ST_IDLE;
        end
      end
      default: state_d = ses_pkg::ST_IDLE;
    endcase

    out_valid_d = out_load || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ses_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      ok_q        <= '0;
      fail_q      <= '0;
      bytes_q     <= '0;
      lat_tot_q   <= '0;
      peak_q      <= '0;
      samples_q   <= '0;
      crc_q       <= '0;
      tmo_q       <= '0;
      irq_q       <= '0;
      rst_evt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ok_q        <= ok_d;
      fail_q      <= fail_d;
      bytes_q     <= bytes_d;
      lat_tot_q   <= lat_tot_d;
      peak_q      <= peak_d;
      samples_q   <= samples_d;
      crc_q       <= crc_d;
      tmo_q       <= tmo_d;
      irq_q       <= irq_d;
      rst_evt_q   <= rst_evt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ela_q       <= ela_d;
    mean_q      <= mean_d;
    tput_q      <= tput_d;
    ratio_q     <= ratio_d;
    out_cv_q    <= out_cv_d;
    out_mean_q  <= out_mean_d;
    out_max_q   <= out_max_d;
    out_tput_q  <= out_tput_d;
    out_ratio_q <= out_ratio_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.counter_value = out_cv_q;
  assign rsp_o.mean_latency  = out_mean_q;
  assign rsp_o.max_latency   = out_max_q;
  assign rsp_o.throughput    = out_tput_q;
  assign rsp_o.success_ratio = out_ratio_q;

  `SES_ASSERT_IMP(a_load_into_free_slot, clk_i, rst_ni, out_load, out_free)
  `SES_ASSERT_IMP(a_div_start_when_idle, clk_i, rst_ni, div_req_o.start, !div_rsp_i.busy)
  `SES_ASSERT_IMP(a_pop_only_idle, clk_i, rst_ni, pop_o, state_q == ses_pkg::ST_IDLE)
  `SES_ASSERT_NEXT(a_ok_saturates, clk_i, rst_ni, (ok_q == '1) && !(pop_o && head_i.cmd == ses_pkg::CMD_CLEAR), ok_q == '1)

endmodule

`default_nettype wire
